// ===== hdl/tlvr_pkg.sv =====
// Shared types and constants of the frame receiver.
// Used by the front end, queue, back end and top level; depends on nothing.
package tlvr_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
	localparam int QUEUE_DEPTH  = 2;
	localparam int MEM_DEPTH    = QUEUE_DEPTH * BUFFER_DEPTH;
	localparam int MEM_AW       = BUF_AW + 1;
	localparam int LEN_W        = 6;
	localparam int IDX_W        = 5;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TYPE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd2;

	typedef struct packed {
		logic [31:0]      timeout;
		logic [7:0]       max_type;
		logic [LEN_W-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       ftype;
		logic [LEN_W-1:0] flen;
		logic [15:0]      csum;
		logic             empty;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic [7:0]       ftype;
		logic [LEN_W-1:0] flen;
		logic [15:0]      csum;
		logic [IDX_W-1:0] idx;
		logic [7:0]       payload;
		logic             empty;
		logic             last;
	} res_t;

endpackage

// ===== hdl/tlvr_front.sv =====
// Front end of the frame receiver: byte parser with gap timeout.
// Writes payload bytes into the back end's buffer and pushes frame descriptors.
// Depends on tlvr_pkg.
module tlvr_front import tlvr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_fire,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] now,
	input  logic        bank,
	output logic        push,
	output desc_t       push_desc,
	output wr_t         wr
);

	typedef enum logic [3:0] {
		PH_TYPE   = 4'b0001,
		PH_LENGTH = 4'b0010,
		PH_CSUM   = 4'b0100,
		PH_DATA   = 4'b1000
	} phase_t;

	phase_t           phase_q, phase_d, ph;
	logic [LEN_W-1:0] cnt_q, cnt_d, cnt, cnt_inc;
	logic [31:0]      last_time_q, gap;
	logic [7:0]       type_q, type_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [15:0]      csum_q, csum_d;
	logic             timed_out;

	always_comb begin
		gap       = now - last_time_q;
		timed_out = gap > cfg.timeout;
		ph        = timed_out ? PH_TYPE : phase_q;
		cnt       = timed_out ? '0 : cnt_q;
		cnt_inc   = cnt + LEN_W'(1);

		phase_d   = ph;
		cnt_d     = cnt;
		type_d    = type_q;
		len_d     = len_q;
		csum_d    = csum_q;
		push      = 1'b0;
		push_desc = '{ftype: type_q, flen: len_q, csum: csum_q, empty: 1'b0};
		wr        = '{en: 1'b0, addr: {bank, cnt[BUF_AW-1:0]}, data: rx_byte};

		unique case (ph)
			PH_TYPE: begin
				if (rx_byte <= cfg.max_type) begin
					type_d  = rx_byte;
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (rx_byte > {2'b00, cfg.max_length} || rx_byte > 8'(BUFFER_DEPTH)) begin
					phase_d = PH_TYPE;
				end else begin
					len_d   = rx_byte[LEN_W-1:0];
					phase_d = PH_CSUM;
				end
			end
			PH_CSUM: begin
				if (cnt == '0) begin
					csum_d = {rx_byte, 8'h00};
					cnt_d  = LEN_W'(1);
				end else begin
					csum_d = {csum_q[15:8], rx_byte};
					cnt_d  = '0;
					if (len_q == '0) begin
						// zero-length frame completes here with one result
						push           = in_fire;
						push_desc.csum = csum_d;
						push_desc.empty = 1'b1;
						phase_d        = PH_TYPE;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				wr.en = in_fire;
				if (cnt_inc >= len_q) begin
					push    = in_fire;
					cnt_d   = '0;
					phase_d = PH_TYPE;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
				phase_d = PH_TYPE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			cnt_q       <= '0;
			last_time_q <= '0;
			type_q      <= '0;
			len_q       <= '0;
			csum_q      <= '0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			last_time_q <= now;
			type_q      <= type_d;
			len_q       <= len_d;
			csum_q      <= csum_d;
		end
	end

endmodule

// ===== hdl/tlvr_queue.sv =====
// Two-entry frame descriptor queue between the parser and the emitter.
// Its pointers also select the payload buffer bank. Depends on tlvr_pkg.
module tlvr_queue import tlvr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output desc_t head,
	output logic  not_empty,
	output logic  full,
	output logic  wr_ptr,
	output logic  rd_ptr
);

	desc_t      entry_q [QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = count_q != 2'd0;
	assign full      = count_q == 2'(QUEUE_DEPTH);
	assign wr_ptr    = wr_ptr_q;
	assign rd_ptr    = rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tlvr_back.sv =====
// Back end of the frame receiver: payload buffer and result emitter.
// Walks the head frame one byte a cycle while the output is not stalled
// into a registered output stage. Depends on tlvr_pkg.
module tlvr_back import tlvr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  wr_t   wr,
	input  desc_t head,
	input  logic  not_empty,
	input  logic  rd_ptr,
	output logic  pop,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rd_data_q;
	logic [BUF_AW-1:0] idx_q;
	logic              s1_valid_s1;
	desc_t             desc_s1;
	logic [BUF_AW-1:0] idx_s1;
	logic              last_s1;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_free, issue, frame_end;

	assign out_free  = !out_valid_q || res_ready;
	assign issue     = not_empty && (!s1_valid_s1 || out_free);
	assign frame_end = head.empty || (LEN_W'(idx_q) + LEN_W'(1) == head.flen);
	assign pop       = issue && frame_end;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// buffer: one write port from the parser, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (issue) begin
			rd_data_q <= mem[{rd_ptr, idx_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			desc_s1 <= head;
			idx_s1  <= idx_q;
			last_s1 <= frame_end;
		end
		if (out_free) begin
			out_q.ftype   <= desc_s1.ftype;
			out_q.flen    <= desc_s1.flen;
			out_q.csum    <= desc_s1.csum;
			out_q.idx     <= IDX_W'(idx_s1);
			out_q.payload <= desc_s1.empty ? 8'h00 : rd_data_q;
			out_q.empty   <= desc_s1.empty;
			out_q.last    <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q       <= frame_end ? '0 : idx_q + BUF_AW'(1);
				s1_valid_s1 <= 1'b1;
			end else if (out_free) begin
				s1_valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

endmodule

// ===== hdl/tlv_frame_receiver.sv =====
// Type-length-checksum frame receiver, top level.
// Takes one byte a cycle while the descriptor queue has room; two frames may wait.
// Results go through the read stage and output register; one a cycle unless stalled.
// Reset clears config to defaults, the parser to the type byte, the queue to empty;
// the payload buffer is not cleared and needs no clearing pass.
// Depends on tlvr_pkg, tlvr_front, tlvr_queue, tlvr_back.
module tlv_frame_receiver import tlvr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,   // rx_byte[7:0], now[39:8]
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// frame_type[7:0], frame_length[13:8], frame_checksum[29:14],
	// byte_index[34:30], payload_byte[42:35], zero fill[47:43]
	output logic [47:0]          m_tdata,
	output logic                 m_tuser,   // empty_frame
	output logic                 m_tlast,   // last result of the frame
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	cfg_t  cfg_q;
	logic  in_fire;
	logic  push, pop, not_empty, full, wr_ptr, rd_ptr;
	desc_t push_desc, head;
	wr_t   wr;
	res_t  res;

	// register writes are always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout    <= 32'd1000;
			cfg_q.max_type   <= 8'd255;
			cfg_q.max_length <= LEN_W'(BUFFER_DEPTH);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TIMEOUT:    cfg_q.timeout    <= cfg_data;
				REG_MAX_TYPE:   cfg_q.max_type   <= cfg_data[7:0];
				REG_MAX_LENGTH: cfg_q.max_length <= cfg_data[LEN_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// hold input while both buffer banks are owned by waiting frames
	assign s_tready = !full;
	assign in_fire  = s_tvalid && s_tready;

	tlvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_fire   (in_fire),
		.rx_byte   (s_tdata[7:0]),
		.now       (s_tdata[39:8]),
		.bank      (wr_ptr),
		.push      (push),
		.push_desc (push_desc),
		.wr        (wr)
	);

	tlvr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full),
		.wr_ptr    (wr_ptr),
		.rd_ptr    (rd_ptr)
	);

	tlvr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.head      (head),
		.not_empty (not_empty),
		.rd_ptr    (rd_ptr),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack result fields, lowest first
	assign m_tdata = {5'b00000, res.payload, res.idx, res.csum, res.flen, res.ftype};
	assign m_tuser = res.empty;
	assign m_tlast = res.last;

endmodule

// ===== hdl/tlvr_checker.sv =====
// Port-level checks on the frame receiver's result stream.
// Attached to tlv_frame_receiver by the bind below; depends on nothing else.
module tlvr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[42:30] == 13'd0
			&& m_tdata[13:8] == 6'd0)
		else $error("empty frame result malformed");

	a_index_in_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> {1'b0, m_tdata[34:30]} < m_tdata[13:8]
			&& (m_tlast == ({1'b0, m_tdata[34:30]} + 6'd1 == m_tdata[13:8])))
		else $error("byte index or last marker inconsistent with length");

endmodule

bind tlv_frame_receiver tlvr_checker u_tlvr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
